// File: hdl/sdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

  // Store geometry and limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_SPREAD = 64;

  localparam int COORD_W    = 8;
  localparam int SIZE_W     = 9;
  localparam int SPREAD_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W     = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // Distance arithmetic widths
  localparam int SQ_D_W     = 14;  // one squared axis distance
  localparam int D2_W       = 15;  // sum of two squared distances
  localparam int M_W        = 13;  // running minimum, at most spread squared
  localparam int RHS_W      = 27;  // 127^2 times minimum
  localparam int G_W        = 7;   // normalized distance 0..127
  localparam int BIT_W      = 3;

  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam logic [7:0] MID_LEVEL = 8'h7F;
  localparam int         MID_SQ    = 127 * 127;

  // Word kinds on the input tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_SCALE        = 3'd2,
    REG_SPREAD       = 3'd3
  } sdf_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SETUP,
    S_CENTER,
    S_CWAIT,
    S_SCAN,
    S_DRAIN,
    S_RHS,
    S_SQ,
    S_SCALE,
    S_CMP,
    S_FSQ,
    S_FSCALE,
    S_DONE
  } sdf_state_t;

  typedef struct packed {
    logic take_load;
    logic take_query;
    logic mult;
    logic setup;
    logic center;
    logic grab_center;
    logic scan;
    logic start_search;
    logic square;
    logic scale_sq;
    logic compare;
    logic final_sel;
    logic emit;
  } sdf_cmd_t;

  typedef struct packed {
    logic oor;
    logic scan_last;
    logic bit_zero;
    logic out_free;
  } sdf_status_t;

endpackage

`default_nettype wire

// File: hdl/sdf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sdf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tuser,
  output logic                  s_tready,
  input  wire sdf_pkg::sdf_status_t status,
  output sdf_pkg::sdf_cmd_t     cmd
);

  sdf_pkg::sdf_state_t state;
  sdf_pkg::sdf_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      sdf_pkg::S_IDLE: begin
        s_tready       = 1'b1;
        cmd.take_load  = s_tvalid && (s_tuser == sdf_pkg::FUNC_LOAD);
        cmd.take_query = s_tvalid && (s_tuser == sdf_pkg::FUNC_QUERY);
        if (cmd.take_query) begin
          state_next = sdf_pkg::S_MUL;
        end
      end
      sdf_pkg::S_MUL: begin
        cmd.mult   = 1'b1;
        state_next = sdf_pkg::S_SETUP;
      end
      sdf_pkg::S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sdf_pkg::S_CENTER;
      end
      sdf_pkg::S_CENTER: begin
        if (status.oor) begin
          state_next = sdf_pkg::S_DONE;
        end else begin
          cmd.center = 1'b1;
          state_next = sdf_pkg::S_CWAIT;
        end
      end
      sdf_pkg::S_CWAIT: begin
        cmd.grab_center = 1'b1;
        state_next      = sdf_pkg::S_SCAN;
      end
      sdf_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = sdf_pkg::S_DRAIN;
        end
      end
      sdf_pkg::S_DRAIN: begin
        state_next = sdf_pkg::S_RHS;
      end
      sdf_pkg::S_RHS: begin
        cmd.start_search = 1'b1;
        state_next       = sdf_pkg::S_SQ;
      end
      sdf_pkg::S_SQ: begin
        cmd.square = 1'b1;
        state_next = sdf_pkg::S_SCALE;
      end
      sdf_pkg::S_SCALE: begin
        cmd.scale_sq = 1'b1;
        state_next   = sdf_pkg::S_CMP;
      end
      sdf_pkg::S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = status.bit_zero ? sdf_pkg::S_FSQ : sdf_pkg::S_SQ;
      end
      sdf_pkg::S_FSQ: begin
        cmd.square    = 1'b1;
        cmd.final_sel = 1'b1;
        state_next    = sdf_pkg::S_FSCALE;
      end
      sdf_pkg::S_FSCALE: begin
        cmd.scale_sq = 1'b1;
        state_next   = sdf_pkg::S_DONE;
      end
      sdf_pkg::S_DONE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sdf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sdf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/sdf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sdf_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write
  input  wire logic                              cfg_valid,
  input  wire logic [sdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sdf_pkg::SIZE_W-1:0]        cfg_data,
  // input word payload
  input  wire logic [sdf_pkg::COORD_W-1:0]       coord_x,
  input  wire logic [sdf_pkg::COORD_W-1:0]       coord_y,
  input  wire logic [7:0]                        blue,
  // output word
  input  wire logic                              m_tready,
  output logic                                   m_tvalid,
  output logic [7:0]                             level,
  output logic                                   out_of_range,
  // control
  input  wire sdf_pkg::sdf_cmd_t                 cmd,
  output sdf_pkg::sdf_status_t                   status
);

  // Configuration registers
  logic [sdf_pkg::SIZE_W-1:0]   image_width;
  logic [sdf_pkg::SIZE_W-1:0]   image_height;
  logic [sdf_pkg::SIZE_W-1:0]   scale;
  logic [sdf_pkg::SPREAD_W-1:0] spread;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sdf_pkg::SIZE_W'(256);
      image_height <= sdf_pkg::SIZE_W'(256);
      scale        <= sdf_pkg::SIZE_W'(1);
      spread       <= sdf_pkg::SPREAD_W'(32);
    end else if (cfg_valid) begin
      case (cfg_index)
        sdf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        sdf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        sdf_pkg::REG_SCALE:        scale        <= cfg_data;
        sdf_pkg::REG_SPREAD:       spread       <= cfg_data[sdf_pkg::SPREAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings after clamping
  logic [sdf_pkg::SIZE_W-1:0]   w_eff;
  logic [sdf_pkg::SIZE_W-1:0]   h_eff;
  logic [sdf_pkg::SIZE_W-1:0]   sc_eff;
  logic [sdf_pkg::SPREAD_W-1:0] sp_eff;

  always_comb begin
    w_eff  = (image_width > sdf_pkg::SIZE_W'(sdf_pkg::MAX_WIDTH))
             ? sdf_pkg::SIZE_W'(sdf_pkg::MAX_WIDTH) : image_width;
    h_eff  = (image_height > sdf_pkg::SIZE_W'(sdf_pkg::MAX_HEIGHT))
             ? sdf_pkg::SIZE_W'(sdf_pkg::MAX_HEIGHT) : image_height;
    sc_eff = (scale == '0) ? sdf_pkg::SIZE_W'(1) : scale;
    if (spread == '0) begin
      sp_eff = sdf_pkg::SPREAD_W'(1);
    end else if (spread > sdf_pkg::SPREAD_W'(sdf_pkg::MAX_SPREAD)) begin
      sp_eff = sdf_pkg::SPREAD_W'(sdf_pkg::MAX_SPREAD);
    end else begin
      sp_eff = spread;
    end
  end

  // Bit store: one read port, one write port, registered read
  logic                         store [sdf_pkg::STORE_DEPTH];
  logic [sdf_pkg::ADDR_W-1:0]   rd_addr;
  logic                         rd_q;

  // Query registers
  logic [sdf_pkg::COORD_W-1:0]  ox;
  logic [sdf_pkg::COORD_W-1:0]  oy;
  logic [sdf_pkg::M_W-1:0]      ss;
  logic [16:0]                  prod_x;
  logic [16:0]                  prod_y;
  logic [sdf_pkg::COORD_W-1:0]  cx;
  logic [sdf_pkg::COORD_W-1:0]  cy;
  logic                         oor;
  logic                         center_in;

  // Scan registers
  logic [sdf_pkg::COORD_W-1:0]  x0;
  logic [sdf_pkg::SIZE_W-1:0]   x1;
  logic [sdf_pkg::SIZE_W-1:0]   y1;
  logic [sdf_pkg::COORD_W-1:0]  x;
  logic [sdf_pkg::COORD_W-1:0]  y;
  logic                         pv;
  logic [sdf_pkg::SQ_D_W-1:0]   dxx;
  logic [sdf_pkg::SQ_D_W-1:0]   dyy;
  logic [sdf_pkg::M_W-1:0]      m;

  // Search registers
  logic [sdf_pkg::RHS_W-1:0]    rhs;
  logic [sdf_pkg::G_W-1:0]      g;
  logic [sdf_pkg::BIT_W-1:0]    bitpos;
  logic [sdf_pkg::SQ_D_W-1:0]   sq;
  logic [sdf_pkg::RHS_W-1:0]    prod;

  // Output register
  logic                         out_valid;
  logic [7:0]                   out_level;
  logic                         out_oor;

  // Combinational helpers
  logic [17:0]                  reach_x;
  logic [17:0]                  reach_y;
  logic [16:0]                  cx_full;
  logic [16:0]                  cy_full;
  logic [sdf_pkg::SIZE_W-1:0]   cx_hi;
  logic [sdf_pkg::SIZE_W-1:0]   cy_hi;
  logic [sdf_pkg::COORD_W-1:0]  sp8;
  logic                         x_last;
  logic                         y_last;
  logic [sdf_pkg::COORD_W-1:0]  dx;
  logic [sdf_pkg::COORD_W-1:0]  dy;
  logic [sdf_pkg::D2_W-1:0]     d2;
  logic [sdf_pkg::G_W-1:0]      cand;
  logic [7:0]                   cost;
  logic [7:0]                   level_calc;

  always_comb begin
    reach_x = 18'(prod_x) + 18'(sc_eff);
    reach_y = 18'(prod_y) + 18'(sc_eff);
    cx_full = prod_x + 17'(sc_eff >> 1);
    cy_full = prod_y + 17'(sc_eff >> 1);
    sp8     = sdf_pkg::COORD_W'(sp_eff);
    cx_hi   = sdf_pkg::SIZE_W'(cx) + sdf_pkg::SIZE_W'(sp_eff);
    cy_hi   = sdf_pkg::SIZE_W'(cy) + sdf_pkg::SIZE_W'(sp_eff);
    x_last  = (sdf_pkg::SIZE_W'(x) + sdf_pkg::SIZE_W'(1)) == x1;
    y_last  = (sdf_pkg::SIZE_W'(y) + sdf_pkg::SIZE_W'(1)) == y1;
    dx      = (x > cx) ? (x - cx) : (cx - x);
    dy      = (y > cy) ? (y - cy) : (cy - y);
    d2      = sdf_pkg::D2_W'(dxx) + sdf_pkg::D2_W'(dyy);
    cand    = cmd.final_sel ? g : (g | (sdf_pkg::G_W'(1) << bitpos));
    rd_addr = cmd.center ? {cy, cx} : {y, x};
  end

  // Write on load words, read every cycle
  always_ff @(posedge clk) begin
    if (cmd.take_load) begin
      store[{coord_y, coord_x}] <= (blue == sdf_pkg::FULL_BYTE);
    end
    rd_q <= store[rd_addr];
  end

  // Query setup: capture coordinates, scale, check range, find the sample
  always_ff @(posedge clk) begin
    if (cmd.take_query) begin
      ox <= coord_x;
      oy <= coord_y;
      ss <= sdf_pkg::M_W'(sp_eff * sp_eff);
    end
    if (cmd.mult) begin
      prod_x <= 17'(ox) * 17'(sc_eff);
      prod_y <= 17'(oy) * 17'(sc_eff);
    end
    if (cmd.setup) begin
      oor <= (reach_x > 18'(w_eff)) || (reach_y > 18'(h_eff));
      cx  <= cx_full[sdf_pkg::COORD_W-1:0];
      cy  <= cy_full[sdf_pkg::COORD_W-1:0];
    end
    if (cmd.grab_center) begin
      center_in <= rd_q;
    end
  end

  // Window walk with a registered compare stage behind the read
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.center) begin
      x0 <= (cx > sp8) ? (cx - sp8) : '0;
      x1 <= (cx_hi < w_eff) ? cx_hi : w_eff;
      y1 <= (cy_hi < h_eff) ? cy_hi : h_eff;
      x  <= (cx > sp8) ? (cx - sp8) : '0;
      y  <= (cy > sp8) ? (cy - sp8) : '0;
      m  <= ss;
    end
    if (cmd.scan) begin
      dxx <= sdf_pkg::SQ_D_W'(dx[sdf_pkg::SPREAD_W-1:0] * dx[sdf_pkg::SPREAD_W-1:0]);
      dyy <= sdf_pkg::SQ_D_W'(dy[sdf_pkg::SPREAD_W-1:0] * dy[sdf_pkg::SPREAD_W-1:0]);
      if (x_last) begin
        x <= x0;
        y <= y + sdf_pkg::COORD_W'(1);
      end else begin
        x <= x + sdf_pkg::COORD_W'(1);
      end
    end
    // keep the nearest pixel of the opposite class
    if (pv && (rd_q != center_in) && (d2 < sdf_pkg::D2_W'(m))) begin
      m <= d2[sdf_pkg::M_W-1:0];
    end
  end

  // Binary search for the largest g with g*g*ss <= 127*127*m
  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      rhs    <= sdf_pkg::RHS_W'(m) * sdf_pkg::RHS_W'(sdf_pkg::MID_SQ);
      g      <= '0;
      bitpos <= sdf_pkg::BIT_W'(sdf_pkg::G_W - 1);
    end
    if (cmd.square) begin
      sq <= sdf_pkg::SQ_D_W'(cand * cand);
    end
    if (cmd.scale_sq) begin
      prod <= sdf_pkg::RHS_W'(sq) * sdf_pkg::RHS_W'(ss);
    end
    if (cmd.compare) begin
      if (prod <= rhs) begin
        g <= cand;
      end
      bitpos <= bitpos - sdf_pkg::BIT_W'(1);
    end
  end

  // Level: round toward the edge, inside rounds its distance up
  always_comb begin
    cost = 8'(g) + ((prod == rhs) ? 8'd0 : 8'd1);
    if (oor) begin
      level_calc = '0;
    end else if (center_in) begin
      level_calc = (cost > sdf_pkg::MID_LEVEL) ? 8'd0 : (sdf_pkg::MID_LEVEL - cost);
    end else begin
      level_calc = sdf_pkg::MID_LEVEL + 8'(g);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_level <= level_calc;
      out_oor   <= oor;
    end
  end

  assign m_tvalid     = out_valid;
  assign level        = out_level;
  assign out_of_range = out_oor;

  assign status.oor       = oor;
  assign status.scan_last = x_last && y_last;
  assign status.bit_zero  = (bitpos == '0);
  assign status.out_free  = !out_valid || m_tready;

endmodule

`default_nettype wire

// File: hdl/signed_distance_field_sampler.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid/s_tready    tdata: coord_x, coord_y, blue; tuser: func
// m_*      out        m_tvalid/m_tready    tdata: level; tuser: out_of_range
// cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load word gives no result.
// A query scans every pixel of its window, up to (2*spread)^2 of them;
// the single read port of the bit store sets the scan rate.
// Synchronous reset clears control and config; the bit store is not cleared.
// A finished result waits in the output register while the next word is taken.

module signed_distance_field_sampler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] coord_x, [15:8] coord_y, [23:16] blue
  input  wire logic        s_tuser,   // [0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] level
  output logic             m_tuser,   // [0] out_of_range
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  sdf_pkg::sdf_cmd_t    cmd;
  sdf_pkg::sdf_status_t status;

  assign cfg_ready = 1'b1;

  sdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sdf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .coord_x      (s_tdata[7:0]),
    .coord_y      (s_tdata[15:8]),
    .blue         (s_tdata[23:16]),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .level        (m_tdata),
    .out_of_range (m_tuser),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire

// File: hdl/sdf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sdf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tuser
);

  // No result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word after reset");

  // Out-of-range results carry level zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0)
    else $error("out of range result with nonzero level");

  // An in-range level never exceeds 254
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata != 8'hFF)
    else $error("level out of span");

  // A load on an idle block gives no result
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
    else $error("result word caused by a load");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind signed_distance_field_sampler sdf_checker u_sdf_checker (.*);

`default_nettype wire

// File: tb/sv/signed_distance_field_sampler_test.sv
`timescale 1ns / 1ps

module signed_distance_field_sampler_test;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 6;
  localparam int MAX_GAP         = 6;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 48;
  localparam int LIMIT_CYCLES    = 2000000;
  localparam int RANDOM_PHASES   = 3;
  localparam int WORDS_PER_PHASE = 8;
  // Index past the last register; writes to it must change nothing
  localparam logic [sdf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

  typedef struct {
    logic       func;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] blue;
  } pix_word_t;

  typedef struct {
    logic [7:0] level;
    logic       oor;
  } sdf_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [7:0] coord_x, [15:8] coord_y, [23:16] blue
  logic        s_tuser = 1'b0; // [0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] level
  logic        m_tuser;        // [0] out_of_range
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  // Register shadows and the geometry they imply
  logic [8:0]  width_reg  = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic [8:0]  scale_reg  = 9'd1;
  logic [6:0]  spread_reg = 7'd32;
  int unsigned img_w, img_h, step, reach;

  // Bit image as the block should hold it, and pixels already queued for load
  bit          img_bits [sdf_pkg::STORE_DEPTH];
  bit          planned  [sdf_pkg::STORE_DEPTH];

  pix_word_t   pending_words[$];
  sdf_result_t expected_levels[$];
  pix_word_t   next_word;
  sdf_result_t got;

  // Source pattern for fill loads
  int          disk_x, disk_y, disk_r, noise_pct;

  bit          word_taken, result_taken;
  bit          burst_mode;
  bit          squeeze_on, squeeze_done;
  int          in_wait, out_wait, hold_left;
  int          cycle_count;
  int          errors, loads_taken, levels_checked, oor_seen, phases_run;

  signed_distance_field_sampler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic void refresh_geometry();
    img_w = (width_reg > sdf_pkg::MAX_WIDTH) ? sdf_pkg::MAX_WIDTH : width_reg;
    img_h = (height_reg > sdf_pkg::MAX_HEIGHT) ? sdf_pkg::MAX_HEIGHT : height_reg;
    step  = (scale_reg == 0) ? 1 : scale_reg;
    if (spread_reg == 0) begin
      reach = 1;
    end else begin
      reach = (spread_reg > sdf_pkg::MAX_SPREAD) ? sdf_pkg::MAX_SPREAD : spread_reg;
    end
  endfunction

  function automatic int unsigned sample_point(input int unsigned o);
    return o * step + step / 2;
  endfunction

  function automatic bit in_grid(input int unsigned ox, input int unsigned oy);
    return (ox < img_w / step) && (oy < img_h / step);
  endfunction

  // Search window, clipped low at zero and high at the image size
  function automatic void scan_window(input int unsigned cx, input int unsigned cy,
                                      output int unsigned x0, output int unsigned x1,
                                      output int unsigned y0, output int unsigned y1);
    x0 = (cx > reach) ? cx - reach : 0;
    y0 = (cy > reach) ? cy - reach : 0;
    x1 = (cx + reach < img_w) ? cx + reach : img_w;
    y1 = (cy + reach < img_h) ? cy + reach : img_h;
  endfunction

  // Distance byte for one output pixel from the current image and geometry
  function automatic sdf_result_t distance_level(input logic [7:0] ox, input logic [7:0] oy);
    sdf_result_t r;
    int unsigned cx, cy, x0, x1, y0, y1, x, y, f, pick;
    longint unsigned best, dx, dy, d2, ss, rhs;
    bit center_in;
    int lv;
    r.level = '0;
    r.oor   = 1'b1;
    if (!in_grid(ox, oy)) return r;
    r.oor     = 1'b0;
    cx        = sample_point(ox);
    cy        = sample_point(oy);
    center_in = img_bits[cy * sdf_pkg::MAX_WIDTH + cx];
    best      = longint'(reach) * reach;
    scan_window(cx, cy, x0, x1, y0, y1);
    for (y = y0; y < y1; y++) begin
      for (x = x0; x < x1; x++) begin
        if (img_bits[y * sdf_pkg::MAX_WIDTH + x] != center_in) begin
          dx = (cx > x) ? cx - x : x - cx;
          dy = (cy > y) ? cy - y : y - cy;
          d2 = dx * dx + dy * dy;
          if (d2 < best) best = d2;
        end
      end
    end
    // Largest f with f^2 * spread^2 <= 127^2 * best, capped at 127
    ss  = longint'(reach) * reach;
    rhs = longint'(sdf_pkg::MID_SQ) * best;
    f   = 0;
    while (f < 127 && (longint'(f) + 1) * (f + 1) * ss <= rhs) f++;
    if (center_in) begin
      pick = (longint'(f) * f * ss == rhs) ? f : f + 1;
      lv   = int'(sdf_pkg::MID_LEVEL) - int'(pick);
      if (lv < 0) lv = 0;
    end else begin
      lv = int'(sdf_pkg::MID_LEVEL) + int'(f);
    end
    r.level = lv[7:0];
    return r;
  endfunction

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [7:0] pattern_blue(input int x, input int y);
    int dx, dy;
    bit in_disk;
    dx      = x - disk_x;
    dy      = y - disk_y;
    in_disk = (dx * dx + dy * dy <= disk_r * disk_r);
    if ($urandom_range(0, 99) < noise_pct) in_disk = !in_disk;
    return in_disk ? sdf_pkg::FULL_BYTE : 8'($urandom_range(0, 254));
  endfunction

  function automatic void push_load(input int unsigned x, input int unsigned y,
                                    input logic [7:0] blue);
    pending_words.push_back('{sdf_pkg::FUNC_LOAD, x[7:0], y[7:0], blue});
    planned[y * sdf_pkg::MAX_WIDTH + x] = 1'b1;
  endfunction

  // Queue a query, first loading every pixel of its window not yet written
  function automatic void ask(input int unsigned ox, input int unsigned oy);
    int unsigned x0, x1, y0, y1, x, y;
    if (in_grid(ox, oy)) begin
      scan_window(sample_point(ox), sample_point(oy), x0, x1, y0, y1);
      for (y = y0; y < y1; y++) begin
        for (x = x0; x < x1; x++) begin
          if (!planned[y * sdf_pkg::MAX_WIDTH + x]) push_load(x, y, pattern_blue(x, y));
        end
      end
    end
    pending_words.push_back('{sdf_pkg::FUNC_QUERY, ox[7:0], oy[7:0],
                              8'($urandom_range(0, 255))});
  endfunction

  function automatic void set_pattern(input int cx, input int cy, input int r,
                                      input int noise);
    disk_x    = cx;
    disk_y    = cy;
    disk_r    = r;
    noise_pct = noise;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  task automatic write_reg(input logic [sdf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [8:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sdf_pkg::REG_IMAGE_WIDTH:  width_reg = value;
      sdf_pkg::REG_IMAGE_HEIGHT: height_reg = value;
      sdf_pkg::REG_SCALE:        scale_reg = value;
      sdf_pkg::REG_SPREAD:       spread_reg = value[6:0];
      default: ;
    endcase
    refresh_geometry();
  endtask

  task automatic configure(input logic [8:0] w, input logic [8:0] h,
                           input logic [8:0] sc, input logic [8:0] sp);
    write_reg(sdf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(sdf_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(sdf_pkg::REG_SCALE, sc);
    write_reg(sdf_pkg::REG_SPREAD, sp);
    @(negedge clk);
    cfg_valid <= 1'b0;
    phases_run++;
  endtask

  // Wait until every word is taken and every level is back, then let loads finish
  task automatic settle();
    while (pending_words.size() != 0 || s_tvalid || expected_levels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d levels outstanding",
               cycle_count, expected_levels.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample both handshakes; predict on taken input words, check taken results
  always @(posedge clk) begin
    word_taken   = !rst && s_tvalid && s_tready;
    result_taken = !rst && m_tvalid && m_tready;
    if (result_taken) begin
      if (expected_levels.size() == 0) begin
        flag_mismatch($sformatf("unexpected word level=%0d oor=%0b", m_tdata, m_tuser));
      end else begin
        got = expected_levels.pop_front();
        if (m_tdata !== got.level)
          flag_mismatch($sformatf("level %0d, want %0d", m_tdata, got.level));
        if (m_tuser !== got.oor)
          flag_mismatch($sformatf("out_of_range %0b, want %0b", m_tuser, got.oor));
        if (got.oor) oor_seen++;
        levels_checked++;
      end
    end
    if (word_taken) begin
      if (s_tuser == sdf_pkg::FUNC_LOAD) begin
        img_bits[s_tdata[15:8] * sdf_pkg::MAX_WIDTH + s_tdata[7:0]] =
          (s_tdata[23:16] == sdf_pkg::FULL_BYTE);
        loads_taken++;
      end else begin
        expected_levels.push_back(distance_level(s_tdata[7:0], s_tdata[15:8]));
      end
    end
  end

  // Input driver: hold a word until taken, then idle for the drawn gap
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (in_wait > 0) begin
        in_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {next_word.blue, next_word.y, next_word.x};
        s_tuser  <= next_word.func;
        in_wait  = draw_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls after each word, one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (result_taken) out_wait = draw_gap();
      if (squeeze_on && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int ph, n, pick;
    refresh_geometry();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corner loads under the reset geometry
    push_load(0, 0, sdf_pkg::FULL_BYTE);
    push_load(255, 255, sdf_pkg::FULL_BYTE);
    push_load(255, 0, 8'd0);
    push_load(0, 255, 8'd254);
    settle();

    // Small image, clean disk: corners, center, edge, and queries past the grid
    configure(9'd8, 9'd6, 9'd1, 9'd2);
    set_pattern(4, 3, 2, 0);
    ask(0, 0);
    ask(7, 5);
    ask(4, 3);
    ask(2, 3);
    ask(8, 0);
    ask(0, 6);
    ask(255, 255);
    settle();

    // Zero width and an oversized scale leave no grid at all
    write_reg(REG_UNUSED, 9'h0AA);
    configure(9'd0, 9'h1FF, 9'h1FF, 9'd1);
    ask(0, 0);
    ask(3, 200);
    settle();

    // Oversized width saturates, zero scale and zero spread act as one
    configure(9'h1FF, 9'd10, 9'd0, 9'd0);
    set_pattern(128, 5, 3, 50);
    ask(255, 9);
    ask(0, 0);
    ask(128, 5);
    ask(255, 255);
    ask(0, 10);
    settle();

    // One output pixel sampled from the middle of the full store
    configure(9'd256, 9'd256, 9'd256, 9'd1);
    set_pattern(128, 128, 1, 30);
    ask(0, 0);
    ask(1, 0);
    ask(0, 1);
    settle();

    // Spread beyond its maximum: the window covers the whole image
    configure(9'd6, 9'd6, 9'd3, 9'd127);
    set_pattern(3, 3, 2, 0);
    ask(0, 0);
    ask(1, 1);
    ask(2, 0);
    settle();

    // Single pixel image at full spread: no opposite pixel, both classes
    configure(9'd1, 9'd1, 9'd1, 9'h1C0);
    ask(0, 0);
    ask(1, 0);
    push_load(0, 0, 8'd0);
    ask(0, 0);
    settle();

    // Random geometries with mixed loads, queries and stray words
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      burst_mode = (ph % 3 == 2);
      configure(9'($urandom_range(4, 10)), 9'($urandom_range(4, 10)),
                9'($urandom_range(1, 2)), 9'($urandom_range(1, 2)));
      set_pattern($urandom_range(0, img_w - 1), $urandom_range(0, img_h - 1),
                  $urandom_range(1, reach + 3), $urandom_range(0, 20));
      if (ph == 1) squeeze_on = 1'b1;
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          push_load($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 1) ? sdf_pkg::FULL_BYTE : 8'($urandom_range(0, 255)));
        end else if (pick < 25) begin
          if ($urandom_range(0, 1))
            ask($urandom_range(img_w / step, 255), $urandom_range(0, 255));
          else
            ask($urandom_range(0, 255), $urandom_range(img_h / step, 255));
        end else begin
          ask($urandom_range(0, img_w / step - 1), $urandom_range(0, img_h / step - 1));
        end
      end
      settle();
    end

    $display("covered %0d register settings, %0d pixel loads, %0d levels checked",
             phases_run, loads_taken, levels_checked);
    $display("%0d queries fell outside the output grid, %0d mismatches", oor_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
